FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the reassembly rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CMTR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define CMTR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CMTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/cmtr_pkg.sv
// shared types and constants for the can multi-frame reassembly block
package cmtr_pkg;

	localparam int HEAD_BYTES = 6;
	localparam int TID_W = 5;
	localparam int DEF_BUFFER_BYTES = 64;
	localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
	localparam int IN_TDATA_W = 104;
	localparam int OUT_TDATA_W = 56;
	localparam logic [2:0] CRC_BYTES = 3'd2;

	typedef struct packed {
		logic [63:0]      data;
		logic [31:0]      time_ms;
		logic             ok;
		logic [2:0]       count;
		logic             is_start;
		logic             is_end;
		logic             toggle;
		logic [TID_W-1:0] tid;
	} frame_t;

	typedef struct packed {
		logic       we;
		logic [7:0] value;
	} lane_wr_t;

	typedef struct packed {
		logic [TID_W-1:0]        tid;
		logic [HEAD_BYTES*8-1:0] record_data;
	} result_t;

endpackage

FILE: hw/rtl/cmtr_parse.sv
// input stage: tail byte decode and frame register
module cmtr_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       frame_data,
	input  logic [3:0]        frame_length,
	input  logic [31:0]       time_ms,
	input  logic              take,
	output logic              valid_s1,
	output cmtr_pkg::frame_t  frame_s1
);

	logic [2:0]       tail_idx;
	logic [7:0]       tail;
	cmtr_pkg::frame_t frame_d;

	always_comb begin
		tail_idx = frame_length[2:0] - 3'd1;
		tail = frame_data[{tail_idx, 3'b000} +: 8];
		frame_d.data = frame_data;
		frame_d.time_ms = time_ms;
		frame_d.ok = (frame_length != 4'd0) && (frame_length <= 4'd8);
		frame_d.count = tail_idx;
		frame_d.is_start = tail[7];
		frame_d.is_end = tail[6];
		frame_d.toggle = tail[5];
		frame_d.tid = tail[cmtr_pkg::TID_W-1:0];
	end

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			frame_s1 <= frame_d;
		end
	end

endmodule

FILE: hw/rtl/cmtr_lane.sv
// one head byte lane: picks the frame byte that lands on its buffer slot
module cmtr_lane #(
	parameter int LANE = 0,
	parameter int FILL_W = 7
) (
	input  logic [63:0]         data,
	input  logic [FILL_W-1:0]   fill,
	input  logic [2:0]          count,
	input  logic [2:0]          pos,
	output cmtr_pkg::lane_wr_t  wr
);

	localparam logic [FILL_W:0] SLOT = (FILL_W+1)'(LANE);

	logic [FILL_W:0] end_pos;
	logic [FILL_W:0] diff;
	logic [2:0]      sel;

	always_comb begin
		end_pos = {1'b0, fill} + {{(FILL_W-2){1'b0}}, count};
		diff = SLOT - {1'b0, fill};
		sel = pos + diff[2:0];
		wr.we = ({1'b0, fill} <= SLOT) && (end_pos > SLOT);
		wr.value = data[{sel, 3'b000} +: 8];
	end

endmodule

FILE: hw/rtl/cmtr_session.sv
// session state, byte lanes and merge of the lane writes into the head store
`include "assert_macros.svh"

module cmtr_session #(
	parameter int BUFFER_BYTES = cmtr_pkg::DEF_BUFFER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic              valid_s1,
	input  cmtr_pkg::frame_t  frame_s1,
	input  logic              room,
	output logic              take,
	output logic              res_valid,
	output cmtr_pkg::result_t res
);

	localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
	localparam int HB = cmtr_pkg::HEAD_BYTES;
	localparam int TW = cmtr_pkg::TID_W;

	logic              valid_q;
	logic [TW-1:0]     tid_q;
	logic              tog_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       last_q;
	logic [31:0]       timeout_q;
	logic [7:0]        head_q [HB];

	logic              valid_n;
	logic [TW-1:0]     tid_n;
	logic              tog_n;
	logic [FILL_W-1:0] fill_n;
	logic [31:0]       last_n;
	logic [7:0]        head_n [HB];
	logic [7:0]        head_new [HB];

	logic [31:0]       elapsed;
	logic [TW-1:0]     tid_diff;
	logic              restart;
	logic [TW-1:0]     eff_tid;
	logic              eff_tog;
	logic [FILL_W-1:0] eff_fill;
	logic              match;
	logic              short_start;
	logic [2:0]        cnt;
	logic [2:0]        pos;
	logic [FILL_W:0]   total;
	logic              overflow;
	logic              store;

	cmtr_pkg::lane_wr_t lane_wr [HB];

	assign take = valid_s1 && room;

	always_comb begin
		elapsed = frame_s1.time_ms - last_q;
		tid_diff = frame_s1.tid - tid_q;
		restart = !valid_q || (elapsed > timeout_q) ||
			(frame_s1.is_start && (tid_diff > TW'(1)));
		eff_tid = restart ? frame_s1.tid : tid_q;
		eff_tog = restart ? 1'b0 : tog_q;
		eff_fill = restart ? '0 : fill_q;
		match = (frame_s1.tid == eff_tid) && (frame_s1.toggle == eff_tog) &&
			!(restart && !frame_s1.is_start);
		short_start = frame_s1.is_start && (frame_s1.count < cmtr_pkg::CRC_BYTES);
		cnt = frame_s1.is_start ? frame_s1.count - cmtr_pkg::CRC_BYTES : frame_s1.count;
		pos = frame_s1.is_start ? cmtr_pkg::CRC_BYTES : 3'd0;
		total = {1'b0, eff_fill} + {{(FILL_W-2){1'b0}}, cnt};
		overflow = total > (FILL_W+1)'(BUFFER_BYTES);
		store = take && frame_s1.ok && match && !short_start && !overflow;
	end

	for (genvar j = 0; j < HB; j++) begin : g_lane
		cmtr_lane #(
			.LANE   (j),
			.FILL_W (FILL_W)
		) u_lane (
			.data  (frame_s1.data),
			.fill  (eff_fill),
			.count (cnt),
			.pos   (pos),
			.wr    (lane_wr[j])
		);
		assign head_new[j] = lane_wr[j].we ? lane_wr[j].value : head_q[j];
		assign res.record_data[8*j +: 8] = head_new[j];
	end

	assign res.tid = eff_tid;
	assign res_valid = store && frame_s1.is_end && (head_new[0] != 8'd0);

	always_comb begin
		valid_n = valid_q;
		tid_n = tid_q;
		tog_n = tog_q;
		fill_n = fill_q;
		last_n = last_q;
		head_n = head_q;
		if (take && frame_s1.ok) begin
			if (restart) begin
				valid_n = 1'b1;
				tid_n = frame_s1.is_start ? frame_s1.tid : frame_s1.tid + TW'(1);
				tog_n = 1'b0;
				fill_n = '0;
			end
			if (match) begin
				last_n = frame_s1.time_ms;
				tog_n = !eff_tog;
				if (!short_start) begin
					if (overflow) begin
						fill_n = '0;
					end else if (frame_s1.is_end) begin
						fill_n = '0;
						tog_n = 1'b0;
						tid_n = eff_tid + TW'(1);
						for (int k = 0; k < HB; k++) begin
							head_n[k] = 8'd0;
						end
					end else begin
						fill_n = total[FILL_W-1:0];
						head_n = head_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tid_q <= '0;
			tog_q <= 1'b0;
			fill_q <= '0;
			last_q <= '0;
			timeout_q <= cmtr_pkg::TIMEOUT_RESET;
			for (int k = 0; k < HB; k++) begin
				head_q[k] <= 8'd0;
			end
		end else begin
			valid_q <= valid_n;
			tid_q <= tid_n;
			tog_q <= tog_n;
			fill_q <= fill_n;
			last_q <= last_n;
			head_q <= head_n;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	`CMTR_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FILL_W'(BUFFER_BYTES))
	`CMTR_ASSERT_NEXT(a_end_clears, clk, arst_n, res_valid, (fill_q == '0) && !tog_q && (head_q[0] == 8'd0))
	`CMTR_ASSERT_IMPLY(a_result_nonzero, clk, arst_n, res_valid, take && (res.record_data[7:0] != 8'd0))

endmodule

FILE: hw/rtl/can_multiframe_transfer_reassembly_top.sv
// top level of the can multi-frame transfer reassembly block
// Takes one CAN frame per clock: a beat accepted on s_axis is decoded into a frame register,
// and the session logic checks it from that register, writes its payload through six byte lanes
// into the head store and, on an accepted end frame with a nonzero first byte, pushes one
// record into a two-entry output buffer, from which m_axis reads. The session update sets the
// rate of one frame per cycle; the input stalls only while both output buffer entries are
// waiting. The user must write the session timeout through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. The timeout resets to 2000 ms.
`include "assert_macros.svh"

module can_multiframe_transfer_reassembly_top #(
	parameter int BUFFER_BYTES = cmtr_pkg::DEF_BUFFER_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [31:0]                         cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// frame_data, frame_length, time_ms
	input  logic [cmtr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// record_data, record_transfer_id
	output logic [cmtr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	logic              valid_s1;
	cmtr_pkg::frame_t  frame_s1;
	logic              take;
	logic              room;
	logic              res_valid;
	cmtr_pkg::result_t res;

	cmtr_pkg::result_t fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;
	cmtr_pkg::result_t head;

	cmtr_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.frame_data   (s_axis_tdata[63:0]),
		.frame_length (s_axis_tdata[67:64]),
		.time_ms      (s_axis_tdata[99:68]),
		.take         (take),
		.valid_s1     (valid_s1),
		.frame_s1     (frame_s1)
	);

	cmtr_session #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_session (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.frame_s1  (frame_s1),
		.room      (room),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	assign room = (cnt_q != 2'd2);
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop = m_axis_tvalid && m_axis_tready;
	assign head = fifo_q[rd_ptr_q];
	assign m_axis_tdata = {3'b000, head.tid, head.record_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (res_valid && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !res_valid) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	`CMTR_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= 2'd2)
	`CMTR_ASSERT_IMPLY(a_no_push_full, clk, arst_n, res_valid, cnt_q != 2'd2)
	`CMTR_ASSERT_IMPLY(a_ptr_one, clk, arst_n, cnt_q == 2'd1, wr_ptr_q != rd_ptr_q)

endmodule
